// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the property checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/idt_pkg.sv =====
package idt_pkg;

    localparam int TIME_W = 48;
    localparam int VAL_W  = 32;
    localparam int TD_W   = 50;
    localparam int DIFF_W = 51;
    localparam int DEL_W  = 49;
    localparam int HALF_W = 25;
    localparam int PROD_W = 58;
    localparam int NUM_W  = 84;
    localparam int CNT_W  = 7;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_STORE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic CFG_DELAY      = 1'b0;
    localparam logic CFG_INIT_VALUE = 1'b1;

    localparam logic signed [VAL_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]               op;
        logic signed [TIME_W-1:0] sample_time;
        logic signed [VAL_W-1:0]  sample_value;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_value;
        logic                    underrun;
    } out_item_t;

    typedef struct packed {
        logic signed [TIME_W-1:0] t;
        logic signed [VAL_W-1:0]  v;
    } entry_t;

    typedef struct packed {
        logic signed [TIME_W-1:0] ti;
        logic signed [TIME_W-1:0] tj;
        logic signed [VAL_W-1:0]  vi;
        logic signed [VAL_W-1:0]  vj;
        logic signed [TD_W-1:0]   td;
    } interp_req_t;

endpackage

// ===== rtl/core/interpolating_transport_delay.sv =====
// Channel   | Handshake                  | Payload
// ----------+----------------------------+------------------------------------
// input     | in_valid / in_stall        | in_item  (op, sample_time, value)
// output    | out_valid / out_stall      | out_item (out_value, underrun)
// config    | cfg_we (no wait)           | cfg_index, cfg_data
//
// One item at a time. Init: one ring entry per cycle. Store: two ring reads,
// one write. Read: binary search on the ring read port, then 5 multiply
// steps and a one-bit-per-cycle divider. Unknown op: answers zero.
// Reset clears state, pointer, out_valid and initial value, sets delay to 1;
// the ring itself is not cleared, so an init must come before any store or
// read. A result waits in the output register under out_stall while the
// next item is already taken.
module interpolating_transport_delay import idt_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_item_t          in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output out_item_t         out_item,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [VAL_W-1:0]  cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_INIT_PREP = 4'd1;
    localparam logic [3:0] S_INIT_FILL = 4'd2;
    localparam logic [3:0] S_ST_OLD    = 4'd3;
    localparam logic [3:0] S_ST_NEW    = 4'd4;
    localparam logic [3:0] S_SRCH      = 4'd5;
    localparam logic [3:0] S_SRCH_CMP  = 4'd6;
    localparam logic [3:0] S_RD_A      = 4'd7;
    localparam logic [3:0] S_RD_B      = 4'd8;
    localparam logic [3:0] S_INTERP    = 4'd9;
    localparam logic [3:0] S_DONE      = 4'd10;

    // (x + w) mod DEPTH, both operands below DEPTH
    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] x,
                                                 input logic [AW-1:0] w);
        logic [AW:0] sum;
        sum = {1'b0, x} + {1'b0, w};
        if (sum >= (AW+1)'(DEPTH))
            sum = sum - (AW+1)'(DEPTH);
        return sum[AW-1:0];
    endfunction

    logic [3:0]               state_reg, state_next;
    logic [31:0]              delay_reg;
    logic signed [VAL_W-1:0]  init_val_reg;
    logic [AW-1:0]            wp_reg, wp_next;
    logic                     out_valid_reg, out_valid_next;
    out_item_t                out_reg, out_next;

    logic signed [TIME_W-1:0] t_reg, t_next;
    logic signed [VAL_W-1:0]  v_reg, v_next;
    logic signed [TD_W-1:0]   td_reg, td_next;
    logic [AW-1:0]            lo_reg, lo_next, hi_reg, hi_next, k_reg, k_next;
    logic [AW-1:0]            idx_reg, idx_next;
    logic signed [TIME_W-1:0] tacc_reg, tacc_next, step_reg, step_next;
    logic signed [TIME_W-1:0] ti_reg, ti_next;
    logic signed [VAL_W-1:0]  vi_reg, vi_next;
    logic signed [VAL_W-1:0]  res_reg, res_next;
    logic                     under_reg, under_next;

    // ring port
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr, mem_raddr;
    entry_t                   mem_wdata, mem_rdata;

    // interpolator
    logic                     ip_start, ip_done;
    interp_req_t              ip_req;
    logic signed [VAL_W-1:0]  ip_result;

    logic                     accept;
    logic                     out_free;
    logic [AW-1:0]            newest;
    logic [AW:0]              mid_sum;
    logic [AW-1:0]            kc;
    logic                     span_gt1;
    logic [TIME_W-1:0]        start_prod;

    assign accept     = in_valid && !in_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign newest     = ring_addr(LAST, wp_reg);
    assign mid_sum    = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign kc         = mid_sum[AW:1];
    assign span_gt1   = (hi_reg - lo_reg) > AW'(1);
    // -(d*(DEPTH-1)) - 1 is the bitwise complement of the product
    assign start_prod = {16'b0, delay_reg} * TIME_W'(DEPTH - 1);

    assign ip_req.ti = ti_reg;
    assign ip_req.tj = mem_rdata.t;
    assign ip_req.vi = vi_reg;
    assign ip_req.vj = mem_rdata.v;
    assign ip_req.td = td_reg;

    // read address: data shows up in the next state
    always_comb
    begin
        case (state_reg)
            S_IDLE:   mem_raddr = wp_reg;
            S_ST_OLD: mem_raddr = newest;
            S_SRCH:   mem_raddr = span_gt1 ? ring_addr(kc, wp_reg)
                                           : ring_addr(lo_reg, wp_reg);
            S_RD_A:   mem_raddr = ring_addr(hi_reg, wp_reg);
            default:  mem_raddr = wp_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        t_next         = t_reg;
        v_next         = v_reg;
        td_next        = td_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        tacc_next      = tacc_reg;
        step_next      = step_reg;
        ti_next        = ti_reg;
        vi_next        = vi_reg;
        res_next       = res_reg;
        under_next     = under_reg;
        mem_we         = 1'b0;
        mem_waddr      = wp_reg;
        mem_wdata.t    = t_reg;
        mem_wdata.v    = v_reg;
        ip_start       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    t_next     = in_item.sample_time;
                    v_next     = in_item.sample_value;
                    td_next    = TD_W'(in_item.sample_time)
                               - $signed({{(TD_W-32){1'b0}}, delay_reg});
                    res_next   = '0;
                    under_next = 1'b0;
                    case (in_item.op)
                        OP_INIT:  state_next = S_INIT_PREP;
                        OP_STORE: state_next = S_ST_OLD;
                        OP_READ:
                        begin
                            lo_next    = '0;
                            hi_next    = LAST;
                            state_next = S_SRCH;
                        end
                        default:  state_next = S_DONE;
                    endcase
                end
            end
            S_INIT_PREP:
            begin
                tacc_next  = $signed(~start_prod);
                step_next  = $signed(TIME_W'(delay_reg) - TIME_W'(1));
                idx_next   = '0;
                state_next = S_INIT_FILL;
            end
            S_INIT_FILL:
            begin
                mem_we      = 1'b1;
                mem_waddr   = idx_reg;
                mem_wdata.t = tacc_reg;
                mem_wdata.v = init_val_reg;
                tacc_next   = tacc_reg + step_reg;
                idx_next    = idx_reg + 1'b1;
                if (idx_reg == LAST)
                begin
                    wp_next    = '0;
                    res_next   = init_val_reg;
                    state_next = S_DONE;
                end
            end
            S_ST_OLD:
            begin
                // oldest entry is on the read port
                under_next = td_reg < TD_W'(mem_rdata.t);
                state_next = S_ST_NEW;
            end
            S_ST_NEW:
            begin
                mem_we = 1'b1;
                if (t_reg > mem_rdata.t)
                begin
                    mem_waddr = wp_reg;
                    wp_next   = ring_addr(AW'(1), wp_reg);
                end
                else
                begin
                    mem_waddr = newest;
                end
                state_next = S_DONE;
            end
            S_SRCH:
            begin
                k_next     = kc;
                state_next = span_gt1 ? S_SRCH_CMP : S_RD_A;
            end
            S_SRCH_CMP:
            begin
                if (td_reg < TD_W'(mem_rdata.t))
                    hi_next = k_reg;
                else if (td_reg > TD_W'(mem_rdata.t))
                    lo_next = k_reg;
                else
                begin
                    lo_next = k_reg;
                    hi_next = k_reg;
                end
                state_next = S_SRCH;
            end
            S_RD_A:
            begin
                ti_next    = mem_rdata.t;
                vi_next    = mem_rdata.v;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                if (mem_rdata.t == ti_reg)
                begin
                    res_next   = vi_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    ip_start   = 1'b1;
                    state_next = S_INTERP;
                end
            end
            S_INTERP:
            begin
                if (ip_done)
                begin
                    res_next   = ip_result;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_next.out_value = res_reg;
                    out_next.underrun  = under_reg;
                    out_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
            delay_reg     <= 32'd1;
            init_val_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DELAY:      delay_reg    <= cfg_data;
                    CFG_INIT_VALUE: init_val_reg <= $signed(cfg_data);
                    default:        delay_reg    <= delay_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        t_reg     <= t_next;
        v_reg     <= v_next;
        td_reg    <= td_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        k_reg     <= k_next;
        idx_reg   <= idx_next;
        tacc_reg  <= tacc_next;
        step_reg  <= step_next;
        ti_reg    <= ti_next;
        vi_reg    <= vi_next;
        res_reg   <= res_next;
        under_reg <= under_next;
    end

    idt_ring #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    idt_interp u_interp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ip_start),
        .req    (ip_req),
        .done   (ip_done),
        .result (ip_result)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// ===== rtl/core/idt_ring.sv =====
// History ring: one write port, one registered read port.
module idt_ring import idt_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/idt_interp.sv =====
// Linear interpolation: four partial products build the numerator, then a
// restoring divider takes one quotient bit per cycle; result saturates.
module idt_interp import idt_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  interp_req_t             req,
    output logic                    done,
    output logic signed [VAL_W-1:0] result
);

    localparam logic [2:0] IP_IDLE = 3'd0;
    localparam logic [2:0] IP_MUL  = 3'd1;
    localparam logic [2:0] IP_ABS  = 3'd2;
    localparam logic [2:0] IP_DIV  = 3'd3;
    localparam logic [2:0] IP_SAT  = 3'd4;

    logic [2:0]               st_reg, st_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     done_reg, done_next;
    logic signed [DIFF_W-1:0] a1_reg, a1_next, a2_reg, a2_next;
    logic signed [DEL_W-1:0]  del_reg, del_next;
    logic signed [VAL_W-1:0]  vi_reg, vi_next, vj_reg, vj_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     pshift_reg, pshift_next;
    logic signed [NUM_W-1:0]  acc_reg, acc_next;
    logic [NUM_W-1:0]         n_reg, n_next;
    logic [DEL_W-1:0]         rem_reg, rem_next, d_reg, d_next;
    logic                     qneg_reg, qneg_next;
    logic signed [VAL_W-1:0]  res_reg, res_next;

    logic signed [DIFF_W-1:0] sel_a;
    logic signed [VAL_W-1:0]  sel_v;
    logic signed [HALF_W:0]   half_c;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [NUM_W-1:0]  prod_ext, addend;
    logic [DEL_W:0]           trial;
    logic                     qbit;

    assign sel_a    = cnt_reg[1] ? a2_reg : a1_reg;
    assign sel_v    = cnt_reg[1] ? vj_reg : vi_reg;
    assign half_c   = cnt_reg[0] ? $signed(sel_a[DIFF_W-1:HALF_W])
                                 : $signed({1'b0, sel_a[HALF_W-1:0]});
    assign prod_c   = half_c * sel_v;
    assign prod_ext = NUM_W'(prod_reg);
    assign addend   = pshift_reg ? (prod_ext <<< HALF_W) : prod_ext;
    assign trial    = {rem_reg, n_reg[NUM_W-1]};
    assign qbit     = (trial >= {1'b0, d_reg});

    always_comb
    begin
        st_next     = st_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        a1_next     = a1_reg;
        a2_next     = a2_reg;
        del_next    = del_reg;
        vi_next     = vi_reg;
        vj_next     = vj_reg;
        prod_next   = prod_reg;
        pshift_next = pshift_reg;
        acc_next    = acc_reg;
        n_next      = n_reg;
        rem_next    = rem_reg;
        d_next      = d_reg;
        qneg_next   = qneg_reg;
        res_next    = res_reg;
        case (st_reg)
            IP_IDLE:
            begin
                if (start)
                begin
                    a1_next  = DIFF_W'(req.tj) - DIFF_W'(req.td);
                    a2_next  = DIFF_W'(req.td) - DIFF_W'(req.ti);
                    del_next = DEL_W'(req.tj) - DEL_W'(req.ti);
                    vi_next  = req.vi;
                    vj_next  = req.vj;
                    acc_next = '0;
                    cnt_next = '0;
                    st_next  = IP_MUL;
                end
            end
            IP_MUL:
            begin
                // product of step n lands in prod_reg, summed at step n+1
                if (cnt_reg != '0)
                begin
                    acc_next = acc_reg + addend;
                end
                prod_next   = prod_c;
                pshift_next = cnt_reg[0];
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(4))
                begin
                    st_next = IP_ABS;
                end
            end
            IP_ABS:
            begin
                qneg_next = acc_reg[NUM_W-1] ^ del_reg[DEL_W-1];
                n_next    = acc_reg[NUM_W-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);
                d_next    = del_reg[DEL_W-1] ? $unsigned(-del_reg) : $unsigned(del_reg);
                rem_next  = '0;
                cnt_next  = '0;
                st_next   = IP_DIV;
            end
            IP_DIV:
            begin
                rem_next = qbit ? DEL_W'(trial - {1'b0, d_reg}) : trial[DEL_W-1:0];
                n_next   = {n_reg[NUM_W-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    st_next = IP_SAT;
                end
            end
            IP_SAT:
            begin
                if (qneg_reg)
                begin
                    if ((|n_reg[NUM_W-1:VAL_W]) || (n_reg[VAL_W-1:0] > 32'h8000_0000))
                        res_next = SAT_MIN;
                    else
                        res_next = -$signed(n_reg[VAL_W-1:0]);
                end
                else
                begin
                    if ((|n_reg[NUM_W-1:VAL_W]) || n_reg[VAL_W-1])
                        res_next = SAT_MAX;
                    else
                        res_next = $signed(n_reg[VAL_W-1:0]);
                end
                done_next = 1'b1;
                st_next   = IP_IDLE;
            end
            default:
            begin
                st_next = IP_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= IP_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        a1_reg     <= a1_next;
        a2_reg     <= a2_next;
        del_reg    <= del_next;
        vi_reg     <= vi_next;
        vj_reg     <= vj_next;
        prod_reg   <= prod_next;
        pshift_reg <= pshift_next;
        acc_reg    <= acc_next;
        n_reg      <= n_next;
        rem_reg    <= rem_next;
        d_reg      <= d_next;
        qneg_reg   <= qneg_next;
        res_reg    <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== rtl/core/idt_checker.sv =====
`include "assert_macros.svh"

module idt_props import idt_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_item
);

    // one item at a time: busy right after an item is taken
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "not busy after accept")

    // a new result only appears after a busy cycle
    `ASSERT_SAME(a_result_from_busy, clk, rst_n, $rose(out_valid), $past(in_stall), "result while idle")

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item), "stalled result changed")

endmodule

bind interpolating_transport_delay idt_props u_idt_props (.*);

// ===== tb/sv/idt_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts each result of the
// delay line and compares accepted results in order.
module idt_checker import idt_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_stall,
    input  in_item_t         in_item,
    input  logic             out_valid,
    input  logic             out_stall,
    input  out_item_t        out_item,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [VAL_W-1:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    localparam int RING = 64;

    // shadow history ring, oldest entry at oldest_idx
    longint      hist_time [RING];
    longint      hist_val  [RING];
    int          oldest_idx;
    logic [31:0] delay_reg;
    longint      init_val_reg;
    out_item_t   expected_q [$];

    // ((tj - td)*vi + (td - ti)*vj) / (tj - ti), truncated toward zero, saturated
    function automatic logic signed [VAL_W-1:0] lerp(longint ti, longint tj,
                                                     longint vi, longint vj,
                                                     longint td);
        logic signed [127:0] a, b, x, y, num, den, q;
        a = tj - td;
        b = td - ti;
        x = vi;
        y = vj;
        num = a * x + b * y;
        den = tj - ti;
        q = num / den;
        if (q > 128'sd2147483647) return SAT_MAX;
        if (q < -128'sd2147483648) return SAT_MIN;
        return q[VAL_W-1:0];
    endfunction

    function automatic out_item_t delay_line_step(in_item_t it);
        out_item_t r;
        longint t, d, td, start;
        int wp, newest, lo, hi, k, ia, ib;
        logic hit;
        t  = it.sample_time;
        d  = longint'({32'd0, delay_reg});
        td = t - d;
        wp = oldest_idx;
        r.out_value = '0;
        r.underrun  = 1'b0;
        case (it.op)
            OP_INIT: begin
                start = -d * (RING - 1) - 1;
                for (int i = 0; i < RING; i++) begin
                    hist_time[i] = start + longint'(i) * (d - 1);
                    hist_val[i]  = init_val_reg;
                end
                oldest_idx  = 0;
                r.out_value = init_val_reg[VAL_W-1:0];
            end
            OP_STORE: begin
                newest     = (wp + RING - 1) % RING;
                r.underrun = td < hist_time[wp];
                if (t > hist_time[newest]) begin
                    hist_time[wp] = t;
                    hist_val[wp]  = longint'(it.sample_value);
                    oldest_idx    = (wp + 1) % RING;
                end else begin
                    hist_time[newest] = t;
                    hist_val[newest]  = longint'(it.sample_value);
                end
            end
            OP_READ: begin
                lo  = 0;
                hi  = RING - 1;
                hit = 1'b0;
                while (hi - lo > 1 && !hit) begin
                    k = (lo + hi) / 2;
                    if (td < hist_time[(k + wp) % RING]) hi = k;
                    else if (td > hist_time[(k + wp) % RING]) lo = k;
                    else begin
                        lo  = k;
                        hi  = k;
                        hit = 1'b1;
                    end
                end
                ia = (lo + wp) % RING;
                ib = (hi + wp) % RING;
                if (hist_time[ia] != hist_time[ib])
                    r.out_value = lerp(hist_time[ia], hist_time[ib],
                                       hist_val[ia], hist_val[ib], td);
                else
                    r.out_value = hist_val[ia][VAL_W-1:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    assign pending = expected_q.size();

    initial
    begin
        fail_count   = 0;
        oldest_idx   = 0;
        delay_reg    = 32'd1;
        init_val_reg = 0;
        for (int i = 0; i < RING; i++)
        begin
            hist_time[i] = 0;
            hist_val[i]  = 0;
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_DELAY) delay_reg = cfg_data;
                else init_val_reg = longint'($signed(cfg_data));
            end
            if (in_valid && !in_stall)
                expected_q.push_back(delay_line_step(in_item));
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with nothing expected: out_value %0d underrun %0d",
                           out_item.out_value, out_item.underrun);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (out_item.out_value !== want.out_value)
                    begin
                        $error("out_value: expected %0d, got %0d",
                               want.out_value, out_item.out_value);
                        fail_count++;
                    end
                    if (out_item.underrun !== want.underrun)
                    begin
                        $error("underrun: expected %0d, got %0d",
                               want.underrun, out_item.underrun);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/interpolating_transport_delay_tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict. Each phase: set delay and initial value while idle,
// init the history, then mostly well-ordered store/read runs with some noise.
module interpolating_transport_delay_tb;
    import idt_pkg::*;

    localparam logic [1:0] OP_NONE   = 2'd3;  // undecoded op, answers zero
    localparam int         SETTLE    = 150;   // longer than a read takes
    localparam longint     CYCLE_CAP = 1500000;
    localparam int         PHASES    = 8;
    localparam int         PER_PHASE = 205;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    in_item_t         in_item = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_item_t        out_item;
    logic             cfg_we = 1'b0;
    logic             cfg_index = CFG_DELAY;
    logic [VAL_W-1:0] cfg_data = '0;
    int               fail_count;
    int               pending;

    longint cycles = 0;
    int     op_count [4];
    int     burst_left = 0;
    longint now_ticks;          // running time cursor for ordered stores
    logic [31:0] cur_delay;

    always #10 clk = ~clk;

    interpolating_transport_delay uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    idt_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: stall segments of varying style, plus one long hold-off
    // so the block backs up and stalls its input
    initial
    begin
        int seg, style, pct;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && cycles > 20000)
            begin
                held = 1'b1;
                for (int i = 0; i < 2000; i++)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end
            seg   = $urandom_range(20, 300);
            style = $urandom_range(0, 3);
            pct   = $urandom_range(10, 80);
            for (int i = 0; i < seg; i++)
            begin
                @(posedge clk);
                case (style)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 99) < pct);
                    2: out_stall <= (i % 5) < 3;
                    default: out_stall <= (i % 17) == 0;
                endcase
            end
        end
    end

    // one item, bursts with random gaps; valid stays up inside a burst
    task automatic send(input logic [1:0] op, input longint t, input logic [31:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        in_item  <= '{op: op, sample_time: t[TIME_W-1:0], sample_value: v};
        do @(posedge clk); while (in_stall);
        burst_left--;
        op_count[op]++;
    endtask

    task automatic wait_idle();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_regs(input logic [31:0] dly, input logic [31:0] iv);
        cur_delay = dly;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DELAY;
        cfg_data  <= dly;
        @(posedge clk);
        cfg_index <= CFG_INIT_VALUE;
        cfg_data  <= iv;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic longint rand48();
        return longint'($signed({$urandom(), $urandom()} << 16)) >>> 16;
    endfunction

    // time near the cursor, scaled to the delay so reads land inside history
    function automatic longint near_time();
        longint span;
        span = (cur_delay > 32'd1000000) ? 1000000 : longint'(cur_delay) + 8;
        return now_ticks + $urandom_range(0, 2 * span) - span
               + ($urandom_range(0, 1) ? longint'(cur_delay) : 0);
    endfunction

    task automatic random_phase(input int n);
        int pick;
        longint step;
        now_ticks = rand48() >>> 6;
        send(OP_INIT, rand48(), $urandom());
        for (int i = 1; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                // mostly advance, sometimes equal or earlier (overwrite newest)
                step = $urandom_range(0, 9) == 0 ? -longint'($urandom_range(0, 50))
                       : longint'($urandom_range(1, 2 * (cur_delay > 50000 ? 50000
                                                         : cur_delay) + 4));
                now_ticks += step;
                send(OP_STORE, now_ticks,
                     $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 20000000));
            end
            else if (pick < 88)
                send(OP_READ, near_time(), $urandom());
            else if (pick < 94)
                send(OP_READ, rand48(), $urandom());      // far extrapolation
            else if (pick < 97)
                send(OP_STORE, rand48(), $urandom());     // out-of-order time
            else if (pick < 99)
                send(OP_NONE, rand48(), $urandom());
            else
                send(OP_INIT, rand48(), $urandom());
        end
    endtask

    initial
    begin
        logic [31:0] dly_set [PHASES];
        logic [31:0] iv_set  [PHASES];
        dly_set = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd7, 32'd1000,
                    $urandom_range(2, 100), 32'd2, $urandom()};
        iv_set  = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                    $urandom(), 32'hFFFF_0000, $urandom(), 32'h0};
        cur_delay = 32'd1;
        for (int i = 0; i < 4; i++) op_count[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: undecoded op before any init, with delay 10 and initial value 0x20000
        set_regs(32'd10, 32'h0002_0000);
        send(OP_NONE, 0, 0);
        send(OP_INIT, 0, 0);
        send(OP_READ, 0, 0);                            // past the init history
        send(OP_STORE, 100, 32'h7FFF_FFFF);
        send(OP_STORE, 110, 32'h8000_0000);
        send(OP_STORE, 110, 32'h0003_0000);             // equal time: overwrite
        send(OP_READ, 115, 0);                          // interpolate
        send(OP_READ, 110, 0);                          // exact hit
        send(OP_READ, 140737488355327, 0);              // extrapolate high, saturate
        send(OP_READ, -140737488355328, 0);             // extrapolate low
        send(OP_STORE, 140737488355327, 32'h8000_0000); // max time
        send(OP_STORE, -140737488355328, 32'h7FFF_FFFF);// earlier: overwrite newest
        send(OP_READ, 0, 0);                            // unordered ring
        send(OP_STORE, -140737488355328, 32'h1);        // underrun at min time
        send(OP_NONE, -1, 32'hFFFF_FFFF);
        send(OP_INIT, -1, 32'hFFFF_FFFF);
        send(OP_STORE, 5, 32'h1234_5678);
        send(OP_READ, -20, 0);
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            set_regs(dly_set[p], iv_set[p]);
            random_phase(PER_PHASE);
            wait_idle();
        end

        $display("ran %0d inits, %0d stores, %0d reads, %0d undecoded ops over %0d phases",
                 op_count[OP_INIT], op_count[OP_STORE], op_count[OP_READ],
                 op_count[OP_NONE], PHASES + 1);
        $display("delays 0, 1 and max and initial values at both rails included");
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/idt_pkg.sv
rtl/core/idt_ring.sv
rtl/core/idt_interp.sv
rtl/core/interpolating_transport_delay.sv
rtl/core/idt_checker.sv
tb/sv/idt_checker.sv
tb/sv/interpolating_transport_delay_tb.sv
